@@ design/dlf_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and rom tables of the dual led flash controller
// no dependencies

package dlf_pkg;

  typedef enum logic [2:0] {
    CMD_SET_TIMEOUT = 3'd0,
    CMD_SET_LEVEL   = 3'd1,
    CMD_ON_OFF      = 3'd2,
    CMD_LEVEL_COUNT = 3'd3,
    CMD_MAX_TORCH   = 3'd4,
    CMD_CURRENT     = 3'd5,
    CMD_HW_TIMEOUT  = 3'd6,
    CMD_MS_TICK     = 3'd7
  } dlf_cmd_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CHANNEL = 2'd1,
    ST_UNKNOWN_CMD = 2'd2
  } dlf_status_e;

  // chip register addresses
  localparam logic [7:0] REG_EN     = 8'h01;
  localparam logic [7:0] REG_FLASH0 = 8'h03;
  localparam logic [7:0] REG_FLASH1 = 8'h04;
  localparam logic [7:0] REG_TORCH0 = 8'h05;
  localparam logic [7:0] REG_TORCH1 = 8'h06;

  // enable register bit groups
  localparam logic [7:0] EN_CH0       = 8'h01;
  localparam logic [7:0] EN_CH1       = 8'h02;
  localparam logic [7:0] EN_TORCH0    = 8'h09;
  localparam logic [7:0] EN_TORCH1    = 8'h0A;
  localparam logic [7:0] EN_FLASH0    = 8'h0D;
  localparam logic [7:0] EN_FLASH1    = 8'h0E;

  localparam logic [10:0] HW_TIMEOUT_MS   = 11'd400;
  localparam int unsigned TIMEOUT_DEFAULT = 100;
  localparam int unsigned LEVEL_W         = 6;

  typedef logic [LEVEL_W-1:0] dlf_level_t;

  typedef struct packed {
    dlf_status_e status;
    logic [10:0] read_value;
    logic        write_valid;
    logic [7:0]  write_addr;
    logic [7:0]  write_data;
    logic        last;
  } dlf_res_t;

  typedef struct packed {
    logic     two;
    dlf_res_t r0;
    dlf_res_t r1;
  } dlf_pair_t;

  function automatic logic [7:0] torch_code(dlf_level_t lv);
    logic [7:0] c;
    case (lv)
      6'd0:    c = 8'h0C;
      6'd1:    c = 8'h17;
      6'd2:    c = 8'h23;
      6'd3:    c = 8'h31;
      6'd4:    c = 8'h3B;
      6'd5:    c = 8'h47;
      6'd6:    c = 8'h53;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] flash_code(dlf_level_t lv);
    logic [7:0] c;
    case (lv)
      6'd0:    c = 8'h03;
      6'd1:    c = 8'h05;
      6'd2:    c = 8'h08;
      6'd3:    c = 8'h0C;
      6'd4:    c = 8'h0E;
      6'd5:    c = 8'h12;
      6'd6:    c = 8'h14;
      6'd7:    c = 8'h19;
      6'd8:    c = 8'h1F;
      6'd9:    c = 8'h26;
      6'd10:   c = 8'h2C;
      6'd11:   c = 8'h32;
      6'd12:   c = 8'h38;
      6'd13:   c = 8'h40;
      6'd14:   c = 8'h46;
      6'd15:   c = 8'h4C;
      6'd16:   c = 8'h53;
      6'd17:   c = 8'h59;
      6'd18:   c = 8'h5F;
      6'd19:   c = 8'h65;
      6'd20:   c = 8'h6D;
      6'd21:   c = 8'h73;
      6'd22:   c = 8'h79;
      6'd23:   c = 8'h7F;
      6'd24:   c = 8'h86;
      6'd25:   c = 8'h8C;
      6'd26:   c = 8'h92;
      6'd27:   c = 8'h99;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [10:0] current_ma(dlf_level_t lv);
    logic [10:0] c;
    case (lv)
      6'd0:    c = 11'd24;
      6'd1:    c = 11'd46;
      6'd2:    c = 11'd70;
      6'd3:    c = 11'd93;
      6'd4:    c = 11'd116;
      6'd5:    c = 11'd141;
      6'd6:    c = 11'd164;
      6'd7:    c = 11'd199;
      6'd8:    c = 11'd246;
      6'd9:    c = 11'd304;
      6'd10:   c = 11'd351;
      6'd11:   c = 11'd398;
      6'd12:   c = 11'd445;
      6'd13:   c = 11'd504;
      6'd14:   c = 11'd551;
      6'd15:   c = 11'd598;
      6'd16:   c = 11'd656;
      6'd17:   c = 11'd703;
      6'd18:   c = 11'd750;
      6'd19:   c = 11'd797;
      6'd20:   c = 11'd856;
      6'd21:   c = 11'd903;
      6'd22:   c = 11'd949;
      6'd23:   c = 11'd996;
      6'd24:   c = 11'd1055;
      6'd25:   c = 11'd1100;
      6'd26:   c = 11'd1147;
      6'd27:   c = 11'd1202;
      default: c = 11'd0;
    endcase
    return c;
  endfunction

endpackage

@@ design/dlf_engine.sv @@
`timescale 1ns / 1ps
// command engine: holds enable shadow, levels and timers, forms up to two results
// depends on dlf_pkg

module dlf_engine #(
  parameter int unsigned LEVEL_COUNT       = 28,
  parameter int unsigned TORCH_LEVEL_COUNT = 7,
  parameter int unsigned TIMER_WIDTH       = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  dlf_pkg::dlf_cmd_e    cmd_i,
  input  logic [1:0]           channel_i,
  input  logic [31:0]          arg_i,
  output dlf_pkg::dlf_pair_t   res_o
);

  localparam logic [TIMER_WIDTH-1:0] TimeoutReset = TIMER_WIDTH'(dlf_pkg::TIMEOUT_DEFAULT);

  logic [7:0]             shadow_q, shadow_d;
  dlf_pkg::dlf_level_t    level_q [2];
  dlf_pkg::dlf_level_t    level_d [2];
  logic [TIMER_WIDTH-1:0] timeout_q [2];
  logic [TIMER_WIDTH-1:0] timeout_d [2];
  logic [TIMER_WIDTH-1:0] remain_q [2];
  logic [TIMER_WIDTH-1:0] remain_d [2];
  logic [1:0]             running_q, running_d;

  function automatic logic [7:0] turn_off(logic [7:0] en, logic ch);
    logic [7:0] r;
    if (!ch) begin
      r = en[1] ? (en & ~dlf_pkg::EN_CH0) : (en & ~dlf_pkg::EN_FLASH0);
    end else begin
      r = en[0] ? (en & ~dlf_pkg::EN_CH1) : (en & ~dlf_pkg::EN_FLASH1);
    end
    return r;
  endfunction

  dlf_pkg::dlf_level_t    lv_clamped;
  logic                   ch;
  logic                   bad_ch;
  logic                   arg_on;
  logic [TIMER_WIDTH-1:0] dec [2];
  logic [1:0]             expire;
  logic [7:0]             en_mid, en_end;
  logic [7:0]             en_on;

  // level clamp shared by set level and the current query
  always_comb begin
    if (arg_i[31]) begin
      lv_clamped = '0;
    end else if (arg_i >= 32'(LEVEL_COUNT)) begin
      lv_clamped = dlf_pkg::LEVEL_W'(LEVEL_COUNT - 1);
    end else begin
      lv_clamped = arg_i[dlf_pkg::LEVEL_W-1:0];
    end
  end

  assign ch     = channel_i[0];
  assign bad_ch = channel_i[1];
  assign arg_on = (arg_i == 32'd1);

  // tick: channel 0 expires first, channel 1 sees its result
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      dec[c]    = remain_q[c] - TIMER_WIDTH'(1);
      expire[c] = running_q[c] && (dec[c] == '0);
    end
    en_mid = expire[0] ? turn_off(shadow_q, 1'b0) : shadow_q;
    en_end = expire[1] ? turn_off(en_mid, 1'b1) : en_mid;
  end

  always_comb begin
    if (32'(level_q[ch]) < 32'(TORCH_LEVEL_COUNT)) begin
      en_on = shadow_q | (ch ? dlf_pkg::EN_TORCH1 : dlf_pkg::EN_TORCH0);
    end else begin
      en_on = shadow_q | (ch ? dlf_pkg::EN_FLASH1 : dlf_pkg::EN_FLASH0);
    end
  end

  // results and next state
  always_comb begin
    dlf_pkg::dlf_res_t empty;
    empty = '{status: dlf_pkg::ST_OK, read_value: '0, write_valid: 1'b0,
              write_addr: '0, write_data: '0, last: 1'b1};
    res_o.two = 1'b0;
    res_o.r0  = empty;
    res_o.r1  = empty;
    shadow_d  = shadow_q;
    running_d = running_q;
    for (int c = 0; c < 2; c++) begin
      level_d[c]   = level_q[c];
      timeout_d[c] = timeout_q[c];
      remain_d[c]  = remain_q[c];
    end

    if (cmd_i == dlf_pkg::CMD_MS_TICK) begin
      for (int c = 0; c < 2; c++) begin
        if (running_q[c]) begin
          remain_d[c] = dec[c];
        end
      end
      running_d = running_q & ~expire;
      shadow_d  = en_end;
      if (expire[0] && expire[1]) begin
        res_o.two            = 1'b1;
        res_o.r0.write_valid = 1'b1;
        res_o.r0.write_addr  = dlf_pkg::REG_EN;
        res_o.r0.write_data  = en_mid;
        res_o.r0.last        = 1'b0;
        res_o.r1.write_valid = 1'b1;
        res_o.r1.write_addr  = dlf_pkg::REG_EN;
        res_o.r1.write_data  = en_end;
      end else if (expire[0] || expire[1]) begin
        res_o.r0.write_valid = 1'b1;
        res_o.r0.write_addr  = dlf_pkg::REG_EN;
        res_o.r0.write_data  = en_end;
      end
    end else if (bad_ch) begin
      res_o.r0.status = dlf_pkg::ST_BAD_CHANNEL;
    end else begin
      case (cmd_i)
        dlf_pkg::CMD_SET_TIMEOUT: begin
          timeout_d[ch] = arg_i[TIMER_WIDTH-1:0];
        end
        dlf_pkg::CMD_SET_LEVEL: begin
          level_d[ch]          = lv_clamped;
          res_o.two            = 1'b1;
          res_o.r0.write_valid = 1'b1;
          res_o.r0.write_addr  = ch ? dlf_pkg::REG_TORCH1 : dlf_pkg::REG_TORCH0;
          res_o.r0.write_data  = dlf_pkg::torch_code(lv_clamped);
          res_o.r0.last        = 1'b0;
          res_o.r1.write_valid = 1'b1;
          res_o.r1.write_addr  = ch ? dlf_pkg::REG_FLASH1 : dlf_pkg::REG_FLASH0;
          res_o.r1.write_data  = dlf_pkg::flash_code(lv_clamped);
        end
        dlf_pkg::CMD_ON_OFF: begin
          if (arg_on) begin
            // zero timeout leaves any running countdown alone
            if (timeout_q[ch] != '0) begin
              remain_d[ch]  = timeout_q[ch];
              running_d[ch] = 1'b1;
            end
            shadow_d = en_on;
          end else begin
            shadow_d      = turn_off(shadow_q, ch);
            running_d[ch] = 1'b0;
            remain_d[ch]  = '0;
          end
          res_o.r0.write_valid = 1'b1;
          res_o.r0.write_addr  = dlf_pkg::REG_EN;
          res_o.r0.write_data  = shadow_d;
        end
        dlf_pkg::CMD_LEVEL_COUNT: res_o.r0.read_value = 11'(LEVEL_COUNT);
        dlf_pkg::CMD_MAX_TORCH:   res_o.r0.read_value = 11'(TORCH_LEVEL_COUNT - 1);
        dlf_pkg::CMD_CURRENT:     res_o.r0.read_value = dlf_pkg::current_ma(lv_clamped);
        dlf_pkg::CMD_HW_TIMEOUT:  res_o.r0.read_value = dlf_pkg::HW_TIMEOUT_MS;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q  <= '0;
      running_q <= '0;
      for (int c = 0; c < 2; c++) begin
        level_q[c]   <= '0;
        timeout_q[c] <= TimeoutReset;
        remain_q[c]  <= '0;
      end
    end else if (fire_i) begin
      shadow_q  <= shadow_d;
      running_q <= running_d;
      for (int c = 0; c < 2; c++) begin
        level_q[c]   <= level_d[c];
        timeout_q[c] <= timeout_d[c];
        remain_q[c]  <= remain_d[c];
      end
    end
  end

  // a running countdown never sits at zero
  a_run_nonzero0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q[0] |-> remain_q[0] != '0) else $error("timer 0 running at zero");
  a_run_nonzero1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q[1] |-> remain_q[1] != '0) else $error("timer 1 running at zero");

endmodule

@@ design/dual_led_flash_controller.sv @@
`timescale 1ns / 1ps
// Two-channel LED flash controller. A command word is registered on entry, worked in one
// pass through the command engine and lands in an output register. A command with one
// result (queries, timeout, on/off, a tick with at most one expiry) can be taken every
// cycle while the output is not stalled; set level on a valid channel and a tick that
// expires both channels give two result words and hold the next command until the first
// word is taken. The second word waits in a spare slot behind the output register. No
// clearing pass: the block takes commands right after reset.
// depends on dlf_pkg and dlf_engine

module dual_led_flash_controller #(
  parameter int unsigned LEVEL_COUNT       = 28,
  parameter int unsigned TORCH_LEVEL_COUNT = 7,
  parameter int unsigned TIMER_WIDTH       = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic [1:0]         channel_i,
  input  logic signed [31:0] arg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [10:0]        read_value_o,
  output logic               write_valid_o,
  output logic [7:0]         write_addr_o,
  output logic [7:0]         write_data_o,
  output logic               last_o
);

  logic               in_vld_q;
  logic [2:0]         cmd_q;
  logic [1:0]         channel_q;
  logic [31:0]        arg_q;
  dlf_pkg::dlf_res_t  out_q, sec_q;
  logic               out_vld_q, sec_vld_q;
  dlf_pkg::dlf_pair_t res;
  logic               adv, fire, accept, out_take;

  assign out_take   = out_vld_q && !out_stall_i;
  assign adv        = !sec_vld_q && (!out_vld_q || !out_stall_i);
  assign fire       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_i;
      channel_q <= channel_i;
      arg_q     <= arg_i;
    end
  end

  dlf_engine #(
    .LEVEL_COUNT      (LEVEL_COUNT),
    .TORCH_LEVEL_COUNT(TORCH_LEVEL_COUNT),
    .TIMER_WIDTH      (TIMER_WIDTH)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .cmd_i    (dlf_pkg::dlf_cmd_e'(cmd_q)),
    .channel_i(channel_q),
    .arg_i    (arg_q),
    .res_o    (res)
  );

  // output word plus one spare slot for the second word of a command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sec_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
      sec_vld_q <= res.two;
    end else if (out_take) begin
      out_vld_q <= sec_vld_q;
      sec_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res.r0;
      sec_q <= res.r1;
    end else if (out_take && sec_vld_q) begin
      out_q <= sec_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_q.status;
  assign read_value_o  = out_q.read_value;
  assign write_valid_o = out_q.write_valid;
  assign write_addr_o  = out_q.write_addr;
  assign write_data_o  = out_q.write_data;
  assign last_o        = out_q.last;

  a_sec_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_vld_q |-> out_vld_q) else $error("spare word without output word");
  a_sec_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_vld_q |-> sec_q.last) else $error("spare word not last");
  a_nonlast_has_follower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.last |-> sec_vld_q) else $error("non-last word without follower");
  a_two_queues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res.two |=> sec_vld_q && out_vld_q) else $error("second word lost");

endmodule

@@ verif/dual_led_flash_controller_chk.sv @@
`timescale 1ns / 1ps
// result checker of the dual led flash controller: watches both channels, keeps its own
// copy of the shadow, levels and countdowns, and compares every result word in order
// depends on dlf_pkg

module dlf_result_checker
  import dlf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         cmd_i,
  input  logic [1:0]         channel_i,
  input  logic signed [31:0] arg_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic [10:0]        read_value_i,
  input  logic               write_valid_i,
  input  logic [7:0]         write_addr_i,
  input  logic [7:0]         write_data_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 expiry_o
);

  localparam int unsigned LEVELS       = 28;
  localparam int unsigned TORCH_LEVELS = 7;

  localparam logic [7:0] TORCH_ROM [0:6] = '{
    8'h0C, 8'h17, 8'h23, 8'h31, 8'h3B, 8'h47, 8'h53
  };
  localparam logic [7:0] FLASH_ROM [0:27] = '{
    8'h03, 8'h05, 8'h08, 8'h0C, 8'h0E, 8'h12, 8'h14, 8'h19, 8'h1F, 8'h26,
    8'h2C, 8'h32, 8'h38, 8'h40, 8'h46, 8'h4C, 8'h53, 8'h59, 8'h5F, 8'h65,
    8'h6D, 8'h73, 8'h79, 8'h7F, 8'h86, 8'h8C, 8'h92, 8'h99
  };
  localparam logic [10:0] MA_ROM [0:27] = '{
    11'd24, 11'd46, 11'd70, 11'd93, 11'd116, 11'd141, 11'd164, 11'd199, 11'd246,
    11'd304, 11'd351, 11'd398, 11'd445, 11'd504, 11'd551, 11'd598, 11'd656,
    11'd703, 11'd750, 11'd797, 11'd856, 11'd903, 11'd949, 11'd996, 11'd1055,
    11'd1100, 11'd1147, 11'd1202
  };

  logic [7:0]  en_shadow;
  dlf_level_t  chan_level [2];
  logic [31:0] chan_timeout [2];
  logic [31:0] ms_left [2];
  logic        timer_on [2];

  dlf_res_t expected_words [$];
  int fails;
  int checked;
  int expiries;

  function automatic dlf_res_t make_word(dlf_status_e st, logic [10:0] rv, logic wv,
                                         logic [7:0] wa, logic [7:0] wd);
    dlf_res_t w;
    w.status      = st;
    w.read_value  = rv;
    w.write_valid = wv;
    w.write_addr  = wa;
    w.write_data  = wd;
    w.last        = 1'b0;
    return w;
  endfunction

  function automatic dlf_level_t clamp_level(logic [31:0] a);
    if (a[31]) return '0;
    if (a >= LEVELS) return dlf_level_t'(LEVELS - 1);
    return a[LEVEL_W-1:0];
  endfunction

  // mode bits go only when the other channel is off, else just the own enable bit
  task automatic drop_channel(input int c);
    if (c == 0) begin
      if ((en_shadow & EN_CH1) != 0) en_shadow &= ~EN_CH0;
      else en_shadow &= ~EN_FLASH0;
    end else begin
      if ((en_shadow & EN_CH0) != 0) en_shadow &= ~EN_CH1;
      else en_shadow &= ~EN_FLASH1;
    end
  endtask

  task automatic predict_words(input logic [2:0] cmd, input logic [1:0] ch,
                               input logic [31:0] a);
    dlf_res_t   w [2];
    int         n;
    int         c;
    dlf_level_t lv;
    n = 0;
    if (dlf_cmd_e'(cmd) == CMD_MS_TICK) begin
      // channel field ignored, channel 0 counts down first
      for (c = 0; c < 2; c++) begin
        if (timer_on[c]) begin
          ms_left[c] = ms_left[c] - 32'd1;
          if (ms_left[c] == '0) begin
            timer_on[c] = 1'b0;
            drop_channel(c);
            w[n] = make_word(ST_OK, '0, 1'b1, REG_EN, en_shadow);
            n++;
            expiries++;
          end
        end
      end
      if (n == 0) begin
        w[0] = make_word(ST_OK, '0, 1'b0, '0, '0);
        n = 1;
      end
    end else if (ch > 2'd1) begin
      w[0] = make_word(ST_BAD_CHANNEL, '0, 1'b0, '0, '0);
      n = 1;
    end else begin
      n = 1;
      case (dlf_cmd_e'(cmd))
        CMD_SET_TIMEOUT: begin
          chan_timeout[ch[0]] = a;
          w[0] = make_word(ST_OK, '0, 1'b0, '0, '0);
        end
        CMD_SET_LEVEL: begin
          lv = clamp_level(a);
          chan_level[ch[0]] = lv;
          w[0] = make_word(ST_OK, '0, 1'b1, ch[0] ? REG_TORCH1 : REG_TORCH0,
                           (lv < TORCH_LEVELS) ? TORCH_ROM[lv] : 8'h00);
          w[1] = make_word(ST_OK, '0, 1'b1, ch[0] ? REG_FLASH1 : REG_FLASH0, FLASH_ROM[lv]);
          n = 2;
        end
        CMD_ON_OFF: begin
          if (a == 32'd1) begin
            // zero timeout leaves a running countdown alone
            if (chan_timeout[ch[0]] != '0) begin
              ms_left[ch[0]]  = chan_timeout[ch[0]];
              timer_on[ch[0]] = 1'b1;
            end
            if (chan_level[ch[0]] < TORCH_LEVELS) en_shadow |= ch[0] ? EN_TORCH1 : EN_TORCH0;
            else en_shadow |= ch[0] ? EN_FLASH1 : EN_FLASH0;
          end else begin
            drop_channel(int'(ch[0]));
            timer_on[ch[0]] = 1'b0;
            ms_left[ch[0]]  = '0;
          end
          w[0] = make_word(ST_OK, '0, 1'b1, REG_EN, en_shadow);
        end
        CMD_LEVEL_COUNT: w[0] = make_word(ST_OK, 11'(LEVELS), 1'b0, '0, '0);
        CMD_MAX_TORCH:   w[0] = make_word(ST_OK, 11'(TORCH_LEVELS - 1), 1'b0, '0, '0);
        CMD_CURRENT:     w[0] = make_word(ST_OK, MA_ROM[clamp_level(a)], 1'b0, '0, '0);
        default:         w[0] = make_word(ST_OK, HW_TIMEOUT_MS, 1'b0, '0, '0);
      endcase
    end
    w[n-1].last = 1'b1;
    for (c = 0; c < n; c++) expected_words.push_back(w[c]);
  endtask

  task automatic check_word();
    dlf_res_t e;
    if (expected_words.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("%0t: unexpected word st=%0d rv=%0d wv=%0d wa=%h wd=%h last=%0d", $realtime,
                 status_i, read_value_i, write_valid_i, write_addr_i, write_data_i, last_i);
    end else begin
      e = expected_words.pop_front();
      checked++;
      if (status_i !== e.status || read_value_i !== e.read_value ||
          write_valid_i !== e.write_valid || write_addr_i !== e.write_addr ||
          write_data_i !== e.write_data || last_i !== e.last) begin
        fails++;
        if (fails <= 10) begin
          $display("%0t: word %0d mismatch, expected st=%0d rv=%0d wv=%0d wa=%h wd=%h last=%0d",
                   $realtime, checked, e.status, e.read_value, e.write_valid, e.write_addr,
                   e.write_data, e.last);
          $display("%0t: word %0d mismatch, got st=%0d rv=%0d wv=%0d wa=%h wd=%h last=%0d",
                   $realtime, checked, status_i, read_value_i, write_valid_i,
                   write_addr_i, write_data_i, last_i);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_shadow       = '0;
      chan_level[0]   = '0;
      chan_level[1]   = '0;
      chan_timeout[0] = TIMEOUT_DEFAULT;
      chan_timeout[1] = TIMEOUT_DEFAULT;
      ms_left[0]      = '0;
      ms_left[1]      = '0;
      timer_on[0]     = 1'b0;
      timer_on[1]     = 1'b0;
      expected_words.delete();
      fails    = 0;
      checked  = 0;
      expiries = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      expiry_o     <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_word();
      if (in_valid_i && !in_stall_i) predict_words(cmd_i, channel_i, arg_i);
      fail_count_o <= fails;
      pending_o    <= expected_words.size();
      checked_o    <= checked;
      expiry_o     <= expiries;
    end
  end

endmodule

@@ verif/dual_led_flash_controller_tb.sv @@
`timescale 1ns / 1ps
// top of the dual led flash controller testbench: clock, reset, command stimulus with
// bursty sender and stalling receiver, watchdog and verdict
// depends on dlf_pkg, dual_led_flash_controller and dlf_result_checker

module dual_led_flash_controller_tb;
  import dlf_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int IDLE_LIMIT   = 4000;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [2:0]         cmd         = '0;
  logic [1:0]         chan        = '0;
  logic signed [31:0] arg         = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [1:0]         status;
  logic [10:0]        read_value;
  logic               write_valid;
  logic [7:0]         write_addr;
  logic [7:0]         write_data;
  logic               res_last;

  int fail_count;
  int pending_words;
  int checked_words;
  int expiry_count;
  int sent_items;
  int directed_items;
  int idle_cycles = 0;

  int       stall_mode  = 0;
  bit [7:0] stall_left  = '0;

  dual_led_flash_controller uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .channel_i     (chan),
    .arg_i         (arg),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .read_value_o  (read_value),
    .write_valid_o (write_valid),
    .write_addr_o  (write_addr),
    .write_data_o  (write_data),
    .last_o        (res_last)
  );

  dlf_result_checker chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .cmd_i         (cmd),
    .channel_i     (chan),
    .arg_i         (arg),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .status_i      (status),
    .read_value_i  (read_value),
    .write_valid_i (write_valid),
    .write_addr_i  (write_addr),
    .write_data_i  (write_data),
    .last_i        (res_last),
    .fail_count_o  (fail_count),
    .pending_o     (pending_words),
    .checked_o     (checked_words),
    .expiry_o      (expiry_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver stall pattern: segments of free flow, light, heavy and periodic stalling
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= 8'($urandom_range(8, 120));
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 8'd1;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_left[3];
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d still expected",
               idle_cycles, pending_words);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_word(input dlf_cmd_e c, input logic [1:0] ch, input logic [31:0] a);
    in_valid <= 1'b1;
    cmd      <= c;
    chan     <= ch;
    arg      <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // a wait before the check so the checker has counted the word accepted last
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int          pick;
    logic [1:0]  ch;
    logic [31:0] a;
    dlf_cmd_e    c;
    pick = $urandom_range(0, 99);
    ch   = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
    a    = $urandom;
    if (pick < 30) begin
      c  = CMD_MS_TICK;
      ch = 2'($urandom);
    end else if (pick < 52) begin
      c = CMD_ON_OFF;
      if ($urandom_range(0, 3) != 0) a = 32'd1;
      else if ($urandom_range(0, 1) == 0) a = 32'd0;
    end else if (pick < 64) begin
      c = CMD_SET_TIMEOUT;
      if ($urandom_range(0, 4) != 0) a = $urandom_range(1, 12);
      else if ($urandom_range(0, 1) == 0) a = 32'd0;
    end else if (pick < 80) begin
      c = CMD_SET_LEVEL;
      if ($urandom_range(0, 3) != 0) a = $urandom_range(0, 31);
    end else if (pick < 88) begin
      c = CMD_CURRENT;
      if ($urandom_range(0, 1) == 0) a = 32'($signed($urandom_range(0, 34)) - 3);
    end else begin
      c = dlf_cmd_e'(3'($urandom_range(3, 6)));
    end
    send_word(c, ch, a);
  endtask

  initial begin
    int burst_left;
    int gap;
    sent_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // queries and clamps at the extremes of the argument
    send_word(CMD_LEVEL_COUNT, 2'd0, 32'd0);
    send_word(CMD_MAX_TORCH,   2'd1, 32'd0);
    send_word(CMD_HW_TIMEOUT,  2'd0, 32'h7FFF_FFFF);
    send_word(CMD_CURRENT,     2'd0, 32'h8000_0000);
    send_word(CMD_CURRENT,     2'd1, 32'd28);
    send_word(CMD_CURRENT,     2'd0, 32'h7FFF_FFFF);
    // bad channels change nothing; then levels clamp and channel 0 starts a countdown
    send_word(CMD_SET_LEVEL,   2'd2, 32'd5);
    send_word(CMD_ON_OFF,      2'd3, 32'd1);
    send_word(CMD_SET_LEVEL,   2'd0, 32'hFFFF_FFFF);
    send_word(CMD_SET_TIMEOUT, 2'd0, 32'd3);
    send_word(CMD_ON_OFF,      2'd0, 32'd1);
    send_word(CMD_SET_LEVEL,   2'd1, 32'd200);
    // zero timeout: channel 1 stays on without a countdown
    send_word(CMD_SET_TIMEOUT, 2'd1, 32'd0);
    send_word(CMD_ON_OFF,      2'd1, 32'd1);
    send_word(CMD_MS_TICK,     2'd3, 32'hFFFF_FFFF);
    send_word(CMD_MS_TICK,     2'd0, 32'd0);
    // channel 0 expires while channel 1 is on: only its own enable bit goes
    send_word(CMD_MS_TICK,     2'd1, 32'd7);
    send_word(CMD_ON_OFF,      2'd1, 32'd2);
    // both channels expire on the same tick
    send_word(CMD_SET_TIMEOUT, 2'd0, 32'd1);
    send_word(CMD_SET_TIMEOUT, 2'd1, 32'd1);
    send_word(CMD_SET_LEVEL,   2'd0, 32'd6);
    send_word(CMD_SET_LEVEL,   2'd1, 32'd7);
    send_word(CMD_ON_OFF,      2'd0, 32'd1);
    send_word(CMD_ON_OFF,      2'd1, 32'd1);
    send_word(CMD_MS_TICK,     2'd2, 32'd0);
    send_word(CMD_SET_TIMEOUT, 2'd0, 32'hFFFF_FFFF);
    send_word(CMD_ON_OFF,      2'd0, 32'hFFFF_FFFF);
    directed_items = sent_items;

    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      random_item();
      if (i % 500 == 250) begin
        drain_results();
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 30) : $urandom_range(1, 3);
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
          burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d commands (%0d directed): all codes, bad channels, level clamps,",
             sent_items, directed_items);
    $display("mode choice and countdowns; %0d result words checked, %0d timer expiries",
             checked_words, expiry_count);
    if (fail_count == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures, %0d words still expected", fail_count, pending_words);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/dlf_pkg.sv
design/dlf_engine.sv
design/dual_led_flash_controller.sv
verif/dual_led_flash_controller_chk.sv
verif/dual_led_flash_controller_tb.sv
